// File: hdl/cpm_pkg.sv
// Shared types, widths and arithmetic helpers for the complex polynomial map core.
package cpm_pkg;

    // Pipeline depth follows the polynomial degree; five coefficient registers exist.
    localparam int DEGREE_DEF = 6;
    localparam int NUM_COEF   = 5;

    localparam int FRAC_W  = 14;
    localparam int Z_W     = 16;                 // input coordinate, Q1.14
    localparam int COEF_W  = 16;                 // one coefficient part, Q1.14
    localparam int ACC_W   = 31;                 // accumulator, saturates to 31 bits
    localparam int ADD_W   = 21;                 // k*c for k up to 9, plus sign
    localparam int PROD_W  = ACC_W + Z_W;        // one partial product
    localparam int SUM_W   = PROD_W + 1;         // sum of two partial products
    localparam int WIDE_W  = SUM_W - FRAC_W;     // after the shift, before saturation
    localparam int OUT_W   = 17;
    localparam int REG_W   = 32;
    localparam int PADDR_W = $clog2(NUM_COEF * 4);
    localparam int IDX_W   = PADDR_W - 2;

    localparam logic signed [ADD_W-1:0]  ONE_Q14 = ADD_W'(16384);
    localparam logic signed [WIDE_W-1:0] ACC_MAX = WIDE_W'(1073741823);
    localparam logic signed [WIDE_W-1:0] ACC_MIN = -WIDE_W'(1073741824);

    typedef logic signed [ACC_W-1:0] t_acc;
    typedef logic signed [Z_W-1:0]   t_z;

    // One item as it moves between pipeline sections.
    typedef struct packed {
        logic vld;
        t_z   zr;
        t_z   zi;
        t_acc pr;
        t_acc pi;
        t_acc dr;
        t_acc di;
    } t_stage;

    function automatic t_acc sat_acc(input logic signed [WIDE_W-1:0] v);
        t_acc res;
        if (v > ACC_MAX) begin
            res = ACC_MAX[ACC_W-1:0];
        end else if (v < ACC_MIN) begin
            res = ACC_MIN[ACC_W-1:0];
        end else begin
            res = v[ACC_W-1:0];
        end
        return res;
    endfunction

    // Combine two partial products, floor-shift by the fraction width, saturate.
    function automatic t_acc prod_fin(input logic signed [PROD_W-1:0] a,
                                      input logic signed [PROD_W-1:0] b,
                                      input logic                     sub);
        logic signed [SUM_W-1:0] s;
        logic signed [SUM_W-1:0] sh;
        if (sub) begin
            s = SUM_W'(a) - SUM_W'(b);
        end else begin
            s = SUM_W'(a) + SUM_W'(b);
        end
        sh = s >>> FRAC_W;
        return sat_acc(sh[WIDE_W-1:0]);
    endfunction

endpackage

// File: hdl/complex_polynomial_map_core.sv
// Top level: complex polynomial map p(z) with |p'(z)|^2, Horner pipeline.
//
//  channel   | handshake                        | payload
//  ----------+----------------------------------+----------------------------------
//  item in   | start (busy always low)          | i_z_real, i_z_imag (Q1.14)
//  item out  | o_valid, one cycle, no back-pres | o_map_real, o_map_imag (Q2.14),
//            |                                  | o_deriv_mod_sq (unsigned Q3.14)
//  config    | APB write psel&penable&pwrite    | paddr, pwdata / prdata, pready
//
// One item enters per cycle. Each Horner step holds two registers (add and
// multiply, then combine and saturate); there are DEGREE steps counting the final
// multiply by z, and the output section holds two more registers.
// Synchronous active-low reset clears the valid chain and the coefficients.
// The receiver cannot stall, so the pipeline never halts; busy is held low.
// Coefficients are read live by every step but the last, so write them only when idle.
module complex_polynomial_map_core #(
    parameter int DEGREE = cpm_pkg::DEGREE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // item in
    input  logic                                start,
    output logic                                busy,
    input  logic signed [cpm_pkg::Z_W-1:0]      i_z_real,
    input  logic signed [cpm_pkg::Z_W-1:0]      i_z_imag,
    // item out
    output logic                                o_valid,
    output logic signed [cpm_pkg::OUT_W-1:0]    o_map_real,
    output logic signed [cpm_pkg::OUT_W-1:0]    o_map_imag,
    output logic        [cpm_pkg::OUT_W-1:0]    o_deriv_mod_sq,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic        [cpm_pkg::PADDR_W-1:0]  paddr,
    input  logic        [cpm_pkg::REG_W-1:0]    pwdata,
    output logic        [cpm_pkg::REG_W-1:0]    prdata,
    output logic                                pready
);
    import cpm_pkg::*;

    localparam int LAT = 2 * DEGREE + 2;

    logic [REG_W-1:0] r_coef [NUM_COEF];
    logic             w_wr;
    logic [IDX_W-1:0] w_idx;

    t_stage w_st [DEGREE+1];

    // ---------------- configuration registers ----------------
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_COEF; i++) begin
                r_coef[i] <= '0;
            end
        end else if (w_wr && (w_idx < IDX_W'(NUM_COEF))) begin
            r_coef[w_idx] <= pwdata;        // out-of-range addresses drop the write
        end
    end

    always_comb begin
        prdata = '0;
        if (w_idx < IDX_W'(NUM_COEF)) begin
            prdata = r_coef[w_idx];
        end
    end

    // ---------------- Horner pipeline ----------------
    assign busy = 1'b0;

    assign w_st[0].vld = start && !busy;
    assign w_st[0].zr  = i_z_real;
    assign w_st[0].zi  = i_z_imag;
    assign w_st[0].pr  = '0;
    assign w_st[0].pi  = '0;
    assign w_st[0].dr  = '0;
    assign w_st[0].di  = '0;

    generate
        for (genvar s = 0; s < DEGREE; s++) begin : g_step
            if (s < DEGREE - 1) begin : g_horner
                // step for degree K, highest degree first
                localparam int K = DEGREE - s;
                localparam logic signed [ADD_W-1:0] KMUL = ADD_W'(K);
                logic signed [COEF_W-1:0] w_cr, w_ci;
                logic signed [ADD_W-1:0]  w_kcr, w_kci;

                if (K - 2 < NUM_COEF) begin : g_reg
                    assign w_cr = r_coef[K-2][REG_W-1:COEF_W];
                    assign w_ci = r_coef[K-2][COEF_W-1:0];
                end else begin : g_zero
                    // no register above degree six: coefficient is zero
                    assign w_cr = '0;
                    assign w_ci = '0;
                end

                assign w_kcr = ADD_W'(w_cr) * KMUL;
                assign w_kci = ADD_W'(w_ci) * KMUL;

                cpm_step #(
                    .MUL_D (1'b1)
                ) u_step (
                    .i_clk     (i_clk),
                    .i_rst_n   (i_rst_n),
                    .i_st      (w_st[s]),
                    .i_p_add_r (ADD_W'(w_cr)),
                    .i_p_add_i (ADD_W'(w_ci)),
                    .i_d_add_r (w_kcr),
                    .i_d_add_i (w_kci),
                    .o_st      (w_st[s+1])
                );
            end else begin : g_last
                // linear term: p gets +1 then one more multiply, p' just gets +1
                cpm_step #(
                    .MUL_D (1'b0)
                ) u_step (
                    .i_clk     (i_clk),
                    .i_rst_n   (i_rst_n),
                    .i_st      (w_st[s]),
                    .i_p_add_r (ONE_Q14),
                    .i_p_add_i ('0),
                    .i_d_add_r (ONE_Q14),
                    .i_d_add_i ('0),
                    .o_st      (w_st[s+1])
                );
            end
        end
    endgenerate

    // ---------------- output section ----------------
    cpm_out u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_st           (w_st[DEGREE]),
        .o_valid        (o_valid),
        .o_map_real     (o_map_real),
        .o_map_imag     (o_map_imag),
        .o_deriv_mod_sq (o_deriv_mod_sq)
    );

    // ---------------- assertions ----------------
    // every accepted item comes out after the fixed latency
    a_lat_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("accepted item did not emerge after pipeline latency");

    // no result without an item accepted the same latency earlier
    a_lat_bwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result strobe without matching accepted item");

    // coefficients only change through a configuration write
    a_coef_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !w_wr) |=> ($stable(r_coef[0]) && $stable(r_coef[1]) &&
                               $stable(r_coef[2]) && $stable(r_coef[3]) &&
                               $stable(r_coef[4])))
        else $error("coefficient changed without a write");

    // derivative modulus never passes its ceiling
    a_dmod_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_deriv_mod_sq <= OUT_W'(65536)))
        else $error("derivative modulus above saturation limit");

endmodule

// File: hdl/cpm_step.sv
// One Horner step: coefficient add, complex multiply by z (derivative only when MUL_D is set), truncate and saturate.
module cpm_step #(
    parameter bit MUL_D = 1'b1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cpm_pkg::t_stage                   i_st,
    input  logic signed [cpm_pkg::ADD_W-1:0]  i_p_add_r,
    input  logic signed [cpm_pkg::ADD_W-1:0]  i_p_add_i,
    input  logic signed [cpm_pkg::ADD_W-1:0]  i_d_add_r,
    input  logic signed [cpm_pkg::ADD_W-1:0]  i_d_add_i,
    output cpm_pkg::t_stage                   o_st
);
    import cpm_pkg::*;

    t_acc w_pa_r, w_pa_i, w_da_r, w_da_i;

    logic                      r_a_vld;
    t_z                        r_a_zr, r_a_zi;
    logic signed [PROD_W-1:0]  r_p_rr, r_p_ii, r_p_ri, r_p_ir;

    logic                      r_b_vld;
    t_z                        r_b_zr, r_b_zi;
    t_acc                      r_b_pr, r_b_pi, r_b_dr, r_b_di;
    t_acc                      w_b_dr, w_b_di;

    // section A: add, saturate, multiply
    assign w_pa_r = sat_acc(WIDE_W'(i_st.pr) + WIDE_W'(i_p_add_r));
    assign w_pa_i = sat_acc(WIDE_W'(i_st.pi) + WIDE_W'(i_p_add_i));
    assign w_da_r = sat_acc(WIDE_W'(i_st.dr) + WIDE_W'(i_d_add_r));
    assign w_da_i = sat_acc(WIDE_W'(i_st.di) + WIDE_W'(i_d_add_i));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            r_a_vld <= i_st.vld;
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_zr <= i_st.zr;
        r_a_zi <= i_st.zi;
        r_p_rr <= PROD_W'(w_pa_r) * PROD_W'(i_st.zr);
        r_p_ii <= PROD_W'(w_pa_i) * PROD_W'(i_st.zi);
        r_p_ri <= PROD_W'(w_pa_r) * PROD_W'(i_st.zi);
        r_p_ir <= PROD_W'(w_pa_i) * PROD_W'(i_st.zr);
    end

    generate
        if (MUL_D) begin : g_dmul
            logic signed [PROD_W-1:0] r_d_rr, r_d_ii, r_d_ri, r_d_ir;
            always_ff @(posedge i_clk) begin
                r_d_rr <= PROD_W'(w_da_r) * PROD_W'(i_st.zr);
                r_d_ii <= PROD_W'(w_da_i) * PROD_W'(i_st.zi);
                r_d_ri <= PROD_W'(w_da_r) * PROD_W'(i_st.zi);
                r_d_ir <= PROD_W'(w_da_i) * PROD_W'(i_st.zr);
            end
            assign w_b_dr = prod_fin(r_d_rr, r_d_ii, 1'b1);
            assign w_b_di = prod_fin(r_d_ri, r_d_ir, 1'b0);
        end else begin : g_dpass
            // last step: derivative only takes its constant term
            t_acc r_d_r, r_d_i;
            always_ff @(posedge i_clk) begin
                r_d_r <= w_da_r;
                r_d_i <= w_da_i;
            end
            assign w_b_dr = r_d_r;
            assign w_b_di = r_d_i;
        end
    endgenerate

    // section B: combine products, shift, saturate
    always_ff @(posedge i_clk) begin
        r_b_zr <= r_a_zr;
        r_b_zi <= r_a_zi;
        r_b_pr <= prod_fin(r_p_rr, r_p_ii, 1'b1);
        r_b_pi <= prod_fin(r_p_ri, r_p_ir, 1'b0);
        r_b_dr <= w_b_dr;
        r_b_di <= w_b_di;
    end

    assign o_st.vld = r_b_vld;
    assign o_st.zr  = r_b_zr;
    assign o_st.zi  = r_b_zi;
    assign o_st.pr  = r_b_pr;
    assign o_st.pi  = r_b_pi;
    assign o_st.dr  = r_b_dr;
    assign o_st.di  = r_b_di;

endmodule

// File: hdl/cpm_out.sv
// Output section: map saturation and squared modulus of the derivative.
module cpm_out (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cpm_pkg::t_stage                     i_st,
    output logic                                o_valid,
    output logic signed [cpm_pkg::OUT_W-1:0]    o_map_real,
    output logic signed [cpm_pkg::OUT_W-1:0]    o_map_imag,
    output logic        [cpm_pkg::OUT_W-1:0]    o_deriv_mod_sq
);
    import cpm_pkg::*;

    localparam int   SQ_W   = 2 * Z_W - 1;             // square of |v| < 2^15
    localparam int   SQS_W  = SQ_W - FRAC_W;
    localparam t_acc SQ_LIM = t_acc'(32767);
    localparam t_acc MAP_LIM = t_acc'(32768);
    localparam logic [OUT_W-1:0] DMOD_MAX = OUT_W'(65536);

    logic signed [Z_W-1:0]      w_dr16, w_di16;
    logic signed [2*Z_W-1:0]    w_sqr, w_sqi;
    logic                       w_big;
    logic signed [OUT_W-1:0]    w_mr, w_mi;

    logic                       r1_vld;
    logic                       r1_big;
    logic        [SQ_W-1:0]     r1_sqr, r1_sqi;
    logic signed [OUT_W-1:0]    r1_mr, r1_mi;
    logic        [OUT_W-1:0]    w_sum;

    logic                       r2_vld;
    logic signed [OUT_W-1:0]    r2_mr, r2_mi;
    logic        [OUT_W-1:0]    r2_dm;

    // beyond +-32767 a square alone already reaches the ceiling
    assign w_big = (i_st.dr > SQ_LIM) || (i_st.dr < -SQ_LIM) ||
                   (i_st.di > SQ_LIM) || (i_st.di < -SQ_LIM);
    assign w_dr16 = i_st.dr[Z_W-1:0];
    assign w_di16 = i_st.di[Z_W-1:0];
    assign w_sqr  = (2*Z_W)'(w_dr16) * (2*Z_W)'(w_dr16);
    assign w_sqi  = (2*Z_W)'(w_di16) * (2*Z_W)'(w_di16);

    always_comb begin
        if (i_st.pr > MAP_LIM) begin
            w_mr = MAP_LIM[OUT_W-1:0];
        end else if (i_st.pr < -MAP_LIM) begin
            w_mr = -MAP_LIM[OUT_W-1:0];
        end else begin
            w_mr = i_st.pr[OUT_W-1:0];
        end
        if (i_st.pi > MAP_LIM) begin
            w_mi = MAP_LIM[OUT_W-1:0];
        end else if (i_st.pi < -MAP_LIM) begin
            w_mi = -MAP_LIM[OUT_W-1:0];
        end else begin
            w_mi = i_st.pi[OUT_W-1:0];
        end
    end

    assign w_sum = OUT_W'(r1_sqr[SQ_W-1:FRAC_W]) + OUT_W'(r1_sqi[SQ_W-1:FRAC_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else begin
            r1_vld <= i_st.vld;
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_big <= w_big;
        r1_sqr <= w_sqr[SQ_W-1:0];
        r1_sqi <= w_sqi[SQ_W-1:0];
        r1_mr  <= w_mr;
        r1_mi  <= w_mi;
        r2_mr  <= r1_mr;
        r2_mi  <= r1_mi;
        if (r1_big || (w_sum > DMOD_MAX)) begin
            r2_dm <= DMOD_MAX;
        end else begin
            r2_dm <= w_sum;
        end
    end

    assign o_valid        = r2_vld;
    assign o_map_real     = r2_mr;
    assign o_map_imag     = r2_mi;
    assign o_deriv_mod_sq = r2_dm;

    // each shifted square stays below 2^16, so two of them fit the output word;
    // the SQS_W-bit field itself must not be wider than that word
    if (SQS_W > OUT_W) begin : g_wcheck
        $error("square width exceeds output width");
    end

endmodule
